// ===== hdl/lcg_pkg.sv =====
package lcg_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned NOISE_W = 24;
  localparam int unsigned OUT_FRAC_BITS_DEF = 23;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned IN_TDATA_W = 96;
  localparam int unsigned OUT_TDATA_W = 56;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_MULT      = 3'd0;
  localparam logic [2:0] REG_INCR      = 3'd1;
  localparam logic [2:0] REG_MOD       = 3'd2;
  localparam logic [2:0] REG_ENABLE    = 3'd3;
  localparam logic [2:0] REG_MULT_SEL  = 3'd4;
  localparam logic [2:0] REG_INCR_SEL  = 3'd5;
  localparam logic [2:0] REG_MOD_SEL   = 3'd6;

  localparam logic [DATA_W-1:0] MULT_RST = 32'd150359821;
  localparam logic [DATA_W-1:0] INCR_RST = 32'd1;
  localparam logic [DATA_W-1:0] MOD_RST  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SEED_RST = 32'hDEAD_BEEF;

endpackage

// ===== hdl/lcg_noise_generator.sv =====
// From input transfer to out_tvalid: operands registered, bit-serial shift-add multiplier
// (32 steps), one restoring divider (modulo, then fraction bits), output register load;
// while disabled, multiplier and divider are skipped. A held output stalls the last step.
// No new input is taken until the item in work has been loaded into the output register.
// Reset (rst_n, synchronous): registers to defaults, generator value 0xDEADBEEF,
// output channel empty.
module lcg_noise_generator #(
  parameter int unsigned OUT_FRAC_BITS = lcg_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [31:0] mult_sample, [63:32] incr_sample, [95:64] mod_sample
  input  logic [lcg_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [23:0] noise_out (signed), [55:24] raw_value
  output logic [lcg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lcg_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import lcg_pkg::*;

  localparam int unsigned DIV_STEPS = DATA_W + OUT_FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned Q_W = OUT_FRAC_BITS + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // configuration registers
  logic [DATA_W-1:0] mult_r, incr_r, mod_r;
  logic              enable_r, mult_sel_r, incr_sel_r, mod_sel_r;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] cv_r, cv_nxt;
  logic [DATA_W-1:0] mcand_r, mcand_nxt;
  logic [DATA_W-1:0] mplier_r, mplier_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] div_m_r, div_m_nxt;
  logic [DATA_W-1:0] dvd_r, dvd_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic              dis_r, dis_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NOISE_W-1:0] out_noise_r, out_noise_nxt;
  logic [DATA_W-1:0] out_raw_r, out_raw_nxt;

  logic [DATA_W-1:0] in_mult, in_incr, in_mod, m_sel;
  logic [DATA_W:0]   rem_sh, rem_diff;
  logic              rem_ge;
  logic [DATA_W:0]   noise_wide;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;
  logic              in_xfer;

  assign in_mult = in_tdata[DATA_W-1:0];
  assign in_incr = in_tdata[2*DATA_W-1:DATA_W];
  assign in_mod  = in_tdata[3*DATA_W-1:2*DATA_W];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_raw_r, out_noise_r};

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_MULT:     cfg_prdata = mult_r;
      REG_INCR:     cfg_prdata = incr_r;
      REG_MOD:      cfg_prdata = mod_r;
      REG_ENABLE:   cfg_prdata = {31'd0, enable_r};
      REG_MULT_SEL: cfg_prdata = {31'd0, mult_sel_r};
      REG_INCR_SEL: cfg_prdata = {31'd0, incr_sel_r};
      REG_MOD_SEL:  cfg_prdata = {31'd0, mod_sel_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r     <= MULT_RST;
      incr_r     <= INCR_RST;
      mod_r      <= MOD_RST;
      enable_r   <= 1'b1;
      mult_sel_r <= 1'b0;
      incr_sel_r <= 1'b0;
      mod_sel_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MULT:     mult_r <= cfg_pwdata;
        REG_INCR:     incr_r <= cfg_pwdata;
        // store a zero modulus as one
        REG_MOD:      mod_r <= (cfg_pwdata == 32'd0) ? 32'd1 : cfg_pwdata;
        REG_ENABLE:   enable_r <= cfg_pwdata[0];
        REG_MULT_SEL: mult_sel_r <= cfg_pwdata[0];
        REG_INCR_SEL: incr_sel_r <= cfg_pwdata[0];
        REG_MOD_SEL:  mod_sel_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (mod_sel_r) begin
      m_sel = (in_mod == 32'd0) ? 32'd1 : in_mod;
    end else begin
      m_sel = mod_r;
    end
  end

  // one restoring division step; the modulo pass shifts in dividend bits,
  // the fraction pass shifts in zeros
  assign rem_sh   = {rem_r, dvd_r[DATA_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_m_r};
  assign rem_ge   = !rem_diff[DATA_W];

  assign noise_wide = (DATA_W+1)'(q_r) - ((DATA_W+1)'(1) << OUT_FRAC_BITS);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cv_nxt        = cv_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    acc_nxt       = acc_r;
    div_m_nxt     = div_m_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    dis_nxt       = dis_r;
    out_valid_nxt = out_valid_r;
    out_noise_nxt = out_noise_r;
    out_raw_nxt   = out_raw_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cnt_nxt    = '0;
          mcand_nxt  = cv_r;
          mplier_nxt = mult_sel_r ? in_mult : mult_r;
          acc_nxt    = incr_sel_r ? in_incr : incr_r;
          div_m_nxt  = m_sel;
          dis_nxt    = !enable_r;
          state_nxt  = enable_r ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        // low 32 bits of value * a + c, one multiplier bit per cycle
        acc_nxt    = acc_r + (mplier_r[0] ? mcand_r : '0);
        mcand_nxt  = {mcand_r[DATA_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[DATA_W-1:1]};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          dvd_nxt   = acc_nxt;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        dvd_nxt = {dvd_r[DATA_W-2:0], 1'b0};
        q_nxt   = {q_r[Q_W-2:0], rem_ge};
        cnt_nxt = cnt_r + 1'b1;
        // remainder after the modulo pass is the new generator value
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          cv_nxt = rem_nxt;
        end
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait for the output register to drain
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_noise_nxt = dis_r ? '0 : noise_wide[NOISE_W-1:0];
          out_raw_nxt   = cv_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cv_r        <= SEED_RST;
      out_valid_r <= 1'b0;
      dis_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cv_r        <= cv_nxt;
      out_valid_r <= out_valid_nxt;
      dis_r       <= dis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    acc_r       <= acc_nxt;
    div_m_r     <= div_m_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    out_noise_r <= out_noise_nxt;
    out_raw_r   <= out_raw_nxt;
  end

endmodule
